[rtl/lfb_pkg.sv]
package lfb_pkg;

   // Window and arithmetic sizes
   localparam int MAX_TAPS      = 15;
   localparam int POS_BITS      = 4;
   localparam int BASE_BITS     = POS_BITS + 1;
   localparam int SAMPLE_BITS   = 8;
   localparam int COEFF_BITS    = 16;
   localparam int PROD_BITS     = SAMPLE_BITS + COEFF_BITS;
   localparam int ACC_BITS      = 28;
   localparam int ROUND_BITS    = ACC_BITS - COEFF_BITS + 2;
   localparam int SAT_MAX       = 255;

   // Configuration port
   localparam int CFG_BITS      = 64;
   localparam int CSR_IDX_BITS  = 3;
   localparam int COEFF_REGS    = 4;
   localparam int CFG_TAP_BITS  = 4;

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] REG_TAP_COUNT     = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_CENTER_OFFSET = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_COEFFS_0      = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_COEFFS_4      = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_COEFFS_8      = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_COEFFS_12     = 3'd5;

   // Window cell operation
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_SHIFT,
      CELL_ROTATE,
      CELL_CLEAR
   } cell_op_type;

   // Multiply-accumulate control
   typedef struct packed {
      logic valid;
      logic first;
   } mac_ctl_type;

endpackage

[rtl/lfb_cell.sv]
module lfb_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  lfb_pkg::cell_op_type             op,
   input  logic [lfb_pkg::SAMPLE_BITS-1:0]  shift_d,
   input  logic [lfb_pkg::SAMPLE_BITS-1:0]  rot_d,
   output logic [lfb_pkg::SAMPLE_BITS-1:0]  q
);

   logic [lfb_pkg::SAMPLE_BITS-1:0] q_ff;
   logic [lfb_pkg::SAMPLE_BITS-1:0] q_in;

   // Pick the next sample: from the newer neighbor on shift, the next one on rotate, zero on clear
   always_comb begin
      case (op)
         lfb_pkg::CELL_SHIFT:  q_in = shift_d;
         lfb_pkg::CELL_ROTATE: q_in = rot_d;
         lfb_pkg::CELL_CLEAR:  q_in = '0;
         default:              q_in = q_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff <= '0;
      end else begin
         q_ff <= q_in;
      end
   end

   assign q = q_ff;

endmodule

[rtl/lfb_mac.sv]
module lfb_mac (
   input  logic                             clock,
   input  logic                             reset,
   input  lfb_pkg::mac_ctl_type             ctl,
   input  logic [lfb_pkg::SAMPLE_BITS-1:0]  sample,
   input  logic [lfb_pkg::COEFF_BITS-1:0]   coeff,
   output logic [lfb_pkg::SAMPLE_BITS-1:0]  result
);

   logic [lfb_pkg::PROD_BITS-1:0]  prod_ff;
   logic [lfb_pkg::PROD_BITS-1:0]  prod_in;
   lfb_pkg::mac_ctl_type           ctl_ff;
   logic [lfb_pkg::ACC_BITS-1:0]   acc_ff;
   logic [lfb_pkg::ACC_BITS-1:0]   acc_in;
   logic [lfb_pkg::ACC_BITS:0]     rnd_sum;
   logic [lfb_pkg::ROUND_BITS-1:0] rnd;

   // Multiply one window sample by its tap weight
   assign prod_in = lfb_pkg::PROD_BITS'(sample) * lfb_pkg::PROD_BITS'(coeff);

   // Accumulate, restarting on the first product of a pass
   assign acc_in = (ctl_ff.first ? '0 : acc_ff) + lfb_pkg::ACC_BITS'(prod_ff);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (ctl_ff.valid) begin
         acc_ff <= acc_in;
      end
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl;
      end
   end

   // Round half up out of the fraction bits, then saturate
   assign rnd_sum = {1'b0, acc_ff}
                  + ((lfb_pkg::ACC_BITS+1)'(1) << (lfb_pkg::COEFF_BITS - 2));
   assign rnd     = rnd_sum[lfb_pkg::ACC_BITS:lfb_pkg::COEFF_BITS-1];
   assign result  = (rnd > lfb_pkg::ROUND_BITS'(lfb_pkg::SAT_MAX))
                  ? lfb_pkg::SAMPLE_BITS'(lfb_pkg::SAT_MAX)
                  : rnd[lfb_pkg::SAMPLE_BITS-1:0];

endmodule

[rtl/line_fir_blur_unit.sv]
// Channel   Ports                          Fields (low bit first)
// request   req_tvalid/tready/tdata/tlast  tdata: in_sample[7:0]; tlast: in_last
// response  rsp_tvalid/tready/tdata/tlast  tdata: out_sample[7:0]; tlast: out_last
// csr       csr_we/csr_index/csr_wdata     write only, index = register number
//
// A taken request shifts into the 15-cell sample window. Each result is then
// formed by rotating the window past the single multiply-accumulate unit,
// draining its pipeline and loading the output register. A line's last
// request yields up to 15 results in a row. Synchronous reset clears the
// window, the line counters and the output valid and last flags and loads
// the default kernel (one tap of 1.0). A stalled response holds the block in
// its load step; the next request is taken while the final result of the
// previous one still waits in the output register.
module line_fir_blur_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [lfb_pkg::SAMPLE_BITS-1:0]    req_tdata,   // in_sample[7:0]
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [lfb_pkg::SAMPLE_BITS-1:0]    rsp_tdata,   // out_sample[7:0]
   output logic                               rsp_tlast,
   input  logic                               csr_we,
   input  logic [lfb_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [lfb_pkg::CFG_BITS-1:0]       csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   state_type                                  state_ff;
   logic [lfb_pkg::CFG_TAP_BITS-1:0]           tap_ff;
   logic [lfb_pkg::CFG_TAP_BITS-1:0]           off_ff;
   logic [lfb_pkg::COEFF_REGS-1:0][lfb_pkg::CFG_BITS-1:0] coef_ff;
   logic [lfb_pkg::POS_BITS-1:0]               seen_ff;
   logic [lfb_pkg::POS_BITS-1:0]               m_ff;
   logic [lfb_pkg::POS_BITS-1:0]               cnt_ff;
   logic [lfb_pkg::POS_BITS-1:0]               j_ff;
   logic                                       last_ff;
   logic                                       rsp_valid_ff;
   logic [lfb_pkg::SAMPLE_BITS-1:0]            rsp_data_ff;
   logic                                       rsp_last_ff;

   logic                                       req_accept;
   logic                                       load;
   logic [lfb_pkg::BASE_BITS-1:0]              lag_raw;
   logic [lfb_pkg::POS_BITS-1:0]               lag;
   logic [lfb_pkg::POS_BITS-1:0]               seen_new;
   logic                                       emit;
   logic [lfb_pkg::POS_BITS-1:0]               start_m;
   logic [lfb_pkg::POS_BITS-1:0]               start_cnt;
   logic [lfb_pkg::BASE_BITS-1:0]              base;
   logic [lfb_pkg::BASE_BITS:0]                kdiff;
   logic                                       tap_ok;
   logic [lfb_pkg::POS_BITS-1:0]               kidx;
   logic [lfb_pkg::COEFF_BITS-1:0]             coeff_sel;
   lfb_pkg::cell_op_type                       cell_op;
   lfb_pkg::mac_ctl_type                       mac_ctl;
   logic [lfb_pkg::SAMPLE_BITS-1:0]            mac_result;
   logic [lfb_pkg::SAMPLE_BITS-1:0]            win_q     [lfb_pkg::MAX_TAPS];
   logic [lfb_pkg::SAMPLE_BITS-1:0]            shift_src [lfb_pkg::MAX_TAPS];
   logic [lfb_pkg::SAMPLE_BITS-1:0]            rot_src   [lfb_pkg::MAX_TAPS];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign load       = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   // Lag between the newest sample and the output it completes
   assign lag_raw = {1'b0, tap_ff} - {1'b0, off_ff} - lfb_pkg::BASE_BITS'(1);
   assign lag     = lag_raw[lfb_pkg::BASE_BITS-1] ? '0 : lag_raw[lfb_pkg::POS_BITS-1:0];

   // Plan the outputs of a request: the regular one, plus the flush on the last
   assign seen_new  = (seen_ff == lfb_pkg::POS_BITS'(lfb_pkg::MAX_TAPS))
                    ? seen_ff : seen_ff + lfb_pkg::POS_BITS'(1);
   assign emit      = (seen_new > lag);
   assign start_m   = emit ? lag : seen_new - lfb_pkg::POS_BITS'(1);
   assign start_cnt = req_tlast ? start_m + lfb_pkg::POS_BITS'(1)
                                : lfb_pkg::POS_BITS'(emit);

   // Tap index for the window position under the accumulator
   assign base   = {1'b0, m_ff} + {1'b0, off_ff};
   assign kdiff  = {1'b0, base} - {2'b00, j_ff};
   assign tap_ok = !kdiff[lfb_pkg::BASE_BITS] &&
                   (kdiff[lfb_pkg::BASE_BITS-1:0] < {1'b0, tap_ff});
   assign kidx   = kdiff[lfb_pkg::POS_BITS-1:0];
   assign coeff_sel = tap_ok ? coef_ff[kidx[3:2]][{kidx[1:0], 4'b0000} +: lfb_pkg::COEFF_BITS]
                             : '0;

   // Window operation for this cycle
   always_comb begin
      cell_op = lfb_pkg::CELL_HOLD;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cell_op = lfb_pkg::CELL_SHIFT;
            end
         end
         ST_SCAN: cell_op = lfb_pkg::CELL_ROTATE;
         ST_DONE: begin
            if (load && last_ff && (cnt_ff == lfb_pkg::POS_BITS'(1))) begin
               cell_op = lfb_pkg::CELL_CLEAR;
            end
         end
         default: cell_op = lfb_pkg::CELL_HOLD;
      endcase
   end

   assign mac_ctl.valid = (state_ff == ST_SCAN);
   assign mac_ctl.first = (j_ff == '0);

   // Window chain: shift toward older cells, rotate toward cell zero
   for (genvar g = 0; g < lfb_pkg::MAX_TAPS; g++) begin : g_win
      if (g == 0) begin : g_head
         assign shift_src[g] = req_tdata;
      end else begin : g_body
         assign shift_src[g] = win_q[g-1];
      end
      if (g == lfb_pkg::MAX_TAPS - 1) begin : g_wrap
         assign rot_src[g] = win_q[0];
      end else begin : g_next
         assign rot_src[g] = win_q[g+1];
      end
      lfb_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .op      (cell_op),
         .shift_d (shift_src[g]),
         .rot_d   (rot_src[g]),
         .q       (win_q[g])
      );
   end

   lfb_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mac_ctl),
      .sample (win_q[0]),
      .coeff  (coeff_sel),
      .result (mac_result)
   );

   // Configuration registers; reset loads tap 0 at 1.0
   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff  <= lfb_pkg::CFG_TAP_BITS'(1);
         off_ff  <= '0;
         coef_ff <= {{((lfb_pkg::COEFF_REGS - 1) * lfb_pkg::CFG_BITS){1'b0}},
                     lfb_pkg::CFG_BITS'(1) << (lfb_pkg::COEFF_BITS - 1)};
      end else if (csr_we) begin
         case (csr_index)
            lfb_pkg::REG_TAP_COUNT:     tap_ff <= csr_wdata[lfb_pkg::CFG_TAP_BITS-1:0];
            lfb_pkg::REG_CENTER_OFFSET: off_ff <= csr_wdata[lfb_pkg::CFG_TAP_BITS-1:0];
            lfb_pkg::REG_COEFFS_0:      coef_ff[0] <= csr_wdata;
            lfb_pkg::REG_COEFFS_4:      coef_ff[1] <= csr_wdata;
            lfb_pkg::REG_COEFFS_8:      coef_ff[2] <= csr_wdata;
            lfb_pkg::REG_COEFFS_12:     coef_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seen_ff      <= '0;
         m_ff         <= '0;
         cnt_ff       <= '0;
         j_ff         <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && !load) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  seen_ff <= seen_new;
                  last_ff <= req_tlast;
                  m_ff    <= start_m;
                  cnt_ff  <= start_cnt;
                  j_ff    <= '0;
                  if (start_cnt != '0) begin
                     state_ff <= ST_SCAN;
                  end
               end
            end
            ST_SCAN: begin
               j_ff <= j_ff + lfb_pkg::POS_BITS'(1);
               if (j_ff == lfb_pkg::POS_BITS'(lfb_pkg::MAX_TAPS - 1)) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: state_ff <= ST_DONE;
            ST_DONE: begin
               if (load) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_last_ff  <= last_ff && (cnt_ff == lfb_pkg::POS_BITS'(1));
                  cnt_ff       <= cnt_ff - lfb_pkg::POS_BITS'(1);
                  if (cnt_ff == lfb_pkg::POS_BITS'(1)) begin
                     if (last_ff) begin
                        seen_ff <= '0;
                     end
                     state_ff <= ST_IDLE;
                  end else begin
                     m_ff     <= m_ff - lfb_pkg::POS_BITS'(1);
                     j_ff     <= '0;
                     state_ff <= ST_SCAN;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Hold result data for the output register
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= mac_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

[rtl/lfb_checker.sv]
module lfb_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [lfb_pkg::SAMPLE_BITS-1:0]    rsp_tdata,
   input  logic                               rsp_tlast
);

   // Stalled response holds its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled response changed");

   // Reset empties the output register
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // A new result never appears right after a request is taken
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("result appeared one cycle after a request");

   // The line's last result leaves the block ready for the next line
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) && rsp_tlast |-> req_tready)
      else $error("not ready after end of line");

endmodule

bind line_fir_blur_unit lfb_checker u_lfb_checker (.*);

[tb/sv/tb_top.sv]
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // Register indexes past the end of the map; writes there must be ignored
   localparam logic [lfb_pkg::CSR_IDX_BITS-1:0] REG_SPARE_A = 3'd6;
   localparam logic [lfb_pkg::CSR_IDX_BITS-1:0] REG_SPARE_B = 3'd7;

   localparam int CFG_QUIET    = 40;    // cycles to let a request with no result settle
   localparam int QUIET_LIMIT  = 3000;  // cycles without any handshake before giving up
   localparam int PHASE_ITEMS  = 28;
   localparam int RANDOM_PHASES = 9;

   typedef struct packed {
      logic [lfb_pkg::SAMPLE_BITS-1:0] sample;
      logic                            last;
   } line_sample_type;

   typedef struct packed {
      logic [lfb_pkg::SAMPLE_BITS-1:0] level;
      logic                            last;
   } blurred_type;

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [lfb_pkg::SAMPLE_BITS-1:0]  req_tdata  = '0;    // in_sample[7:0]
   logic                             req_tlast  = 1'b0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [lfb_pkg::SAMPLE_BITS-1:0]  rsp_tdata;          // out_sample[7:0]
   logic                             rsp_tlast;
   logic                             csr_we     = 1'b0;
   logic [lfb_pkg::CSR_IDX_BITS-1:0] csr_index  = '0;
   logic [lfb_pkg::CFG_BITS-1:0]     csr_wdata  = '0;

   line_sample_type line_q[$];     // samples waiting to be sent
   blurred_type     blurred_q[$];  // filtered samples still owed by the block

   // Kernel copy and line history of the predictor
   logic [3:0]                      kernel_taps;
   logic [3:0]                      kernel_offset;
   logic [lfb_pkg::CFG_BITS-1:0]    kernel_coeff[lfb_pkg::COEFF_REGS];
   logic [lfb_pkg::SAMPLE_BITS-1:0] hist[lfb_pkg::MAX_TAPS];
   int                              line_fill;

   int req_issued    = 0;
   int req_accepted  = 0;
   int results_seen  = 0;
   int lines_sent    = 0;
   int kernels_used  = 0;
   int error_count   = 0;
   int quiet_cycles  = 0;
   int burst_left    = 1;
   int gap_left      = 0;
   int rdy_run_left  = 0;
   bit rdy_state     = 1'b0;

   line_fir_blur_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic logic [15:0] kernel_tap(int k);
      if (k < 0 || k >= lfb_pkg::MAX_TAPS) return '0;
      return kernel_coeff[k >> 2][(k % 4) * 16 +: 16];
   endfunction

   function automatic int line_lag();
      int d;
      d = int'(kernel_taps) - 1 - int'(kernel_offset);
      return (d < 0) ? 0 : d;
   endfunction

   // Filtered value for the sample d places behind the newest one
   function automatic logic [lfb_pkg::SAMPLE_BITS-1:0] blur_at(int d);
      longint unsigned acc;
      int j;
      acc = 0;
      for (int k = 0; k < int'(kernel_taps); k++) begin
         j = d + int'(kernel_offset) - k;
         if (j >= 0 && j < lfb_pkg::MAX_TAPS)
            acc += 64'(hist[j]) * 64'(kernel_tap(k));
      end
      acc = (acc + (64'd1 << (lfb_pkg::COEFF_BITS - 2))) >> (lfb_pkg::COEFF_BITS - 1);
      return (acc > lfb_pkg::SAT_MAX) ? lfb_pkg::SAMPLE_BITS'(lfb_pkg::SAT_MAX)
                                      : acc[lfb_pkg::SAMPLE_BITS-1:0];
   endfunction

   function automatic void clear_line();
      foreach (hist[i]) hist[i] = '0;
      line_fill = 0;
   endfunction

   function automatic void predict_request(logic [lfb_pkg::SAMPLE_BITS-1:0] sample,
                                           logic last);
      int d;
      int pending;
      blurred_type r;
      d = line_lag();
      for (int j = lfb_pkg::MAX_TAPS - 1; j > 0; j--) hist[j] = hist[j-1];
      hist[0] = sample;
      if (line_fill < 15) line_fill++;
      pending = (line_fill < d) ? line_fill : d;
      if (line_fill > d) begin
         r.level = blur_at(d);
         r.last  = last && (pending == 0);
         blurred_q.push_back(r);
      end
      // flush the outputs still waiting for right-hand neighbors
      if (last) begin
         for (int m = pending - 1; m >= 0; m--) begin
            r.level = blur_at(m);
            r.last  = (m == 0);
            blurred_q.push_back(r);
         end
         clear_line();
      end
   endfunction

   // ---------------------------------------------------------------- request driver

   always @(negedge clock) begin
      if (req_tvalid && req_issued != req_accepted) begin
         // hold the request until it is taken
      end else if (gap_left > 0) begin
         gap_left--;
         req_tvalid <= 1'b0;
      end else if (line_q.size() > 0) begin
         req_tvalid <= 1'b1;
         req_tdata  <= line_q[0].sample;
         req_tlast  <= line_q[0].last;
         req_issued++;
         if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         end else begin
            burst_left--;
         end
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // ---------------------------------------------------------------- response stall pattern

   always @(negedge clock) begin
      if (rdy_run_left > 0) begin
         rdy_run_left--;
      end else begin
         rdy_state = ~rdy_state;
         if (rdy_state)
            rdy_run_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                        : $urandom_range(1, 8);
         else
            rdy_run_left = $urandom_range(1, 20);
      end
      rsp_tready <= rdy_state;
   end

   // ---------------------------------------------------------------- monitor and checker

   always @(posedge clock) begin
      blurred_type want;
      bit moved;
      moved = 1'b0;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            moved = 1'b1;
            results_seen++;
            if (blurred_q.size() == 0) begin
               $display("%0t: unexpected result: expected none, got sample %0d last %0b",
                        $time, rsp_tdata, rsp_tlast);
               error_count++;
            end else begin
               want = blurred_q.pop_front();
               if (rsp_tdata !== want.level) begin
                  $display("%0t: out_sample mismatch: expected %0d, got %0d",
                           $time, want.level, rsp_tdata);
                  error_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $display("%0t: out_last mismatch: expected %0b, got %0b",
                           $time, want.last, rsp_tlast);
                  error_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            moved = 1'b1;
            predict_request(req_tdata, req_tlast);
            void'(line_q.pop_front());
            req_accepted++;
         end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
   end

   // Abort when neither side moves for too long
   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("tb_top failed");
      $finish;
   end

   // ---------------------------------------------------------------- stimulus helpers

   task automatic write_reg(logic [lfb_pkg::CSR_IDX_BITS-1:0] idx,
                            logic [lfb_pkg::CFG_BITS-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
      case (idx)
         lfb_pkg::REG_TAP_COUNT:     kernel_taps     = val[3:0];
         lfb_pkg::REG_CENTER_OFFSET: kernel_offset   = val[3:0];
         lfb_pkg::REG_COEFFS_0:      kernel_coeff[0] = val;
         lfb_pkg::REG_COEFFS_4:      kernel_coeff[1] = val;
         lfb_pkg::REG_COEFFS_8:      kernel_coeff[2] = val;
         lfb_pkg::REG_COEFFS_12:     kernel_coeff[3] = val;
         default: ;
      endcase
   endtask

   // Tap and offset go out with random upper bits, which the block must drop
   task automatic load_kernel(int taps, int offs, logic [lfb_pkg::CFG_BITS-1:0] c0,
                              logic [lfb_pkg::CFG_BITS-1:0] c1,
                              logic [lfb_pkg::CFG_BITS-1:0] c2,
                              logic [lfb_pkg::CFG_BITS-1:0] c3);
      logic [lfb_pkg::CFG_BITS-1:0] w;
      w = {$urandom, $urandom};
      w[3:0] = taps[3:0];
      write_reg(lfb_pkg::REG_TAP_COUNT, w);
      w = {$urandom, $urandom};
      w[3:0] = offs[3:0];
      write_reg(lfb_pkg::REG_CENTER_OFFSET, w);
      write_reg(lfb_pkg::REG_COEFFS_0, c0);
      write_reg(lfb_pkg::REG_COEFFS_4, c1);
      write_reg(lfb_pkg::REG_COEFFS_8, c2);
      write_reg(lfb_pkg::REG_COEFFS_12, c3);
      kernels_used++;
   endtask

   // Wait until every request is taken and every result is back, then idle a bit
   task automatic settle(int extra);
      while (line_q.size() != 0 || blurred_q.size() != 0) @(negedge clock);
      repeat (extra) @(negedge clock);
   endtask

   task automatic push_sample(logic [lfb_pkg::SAMPLE_BITS-1:0] s, logic last);
      line_sample_type it;
      it.sample = s;
      it.last   = last;
      line_q.push_back(it);
      if (last) lines_sent++;
   endtask

   function automatic logic [lfb_pkg::SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return lfb_pkg::SAMPLE_BITS'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic queue_line(int len, bit closed);
      for (int i = 0; i < len; i++)
         push_sample(pick_sample(), closed && (i == len - 1));
   endtask

   // Style 0: raw bits, 1: blur-like small taps, 2: mix of zero, one, full scale and raw bits
   function automatic logic [lfb_pkg::CFG_BITS-1:0] pick_coeff_word(int style, int taps);
      logic [lfb_pkg::CFG_BITS-1:0] w;
      w = {$urandom, $urandom};
      for (int s = 0; s < 4; s++) begin
         if (style == 1)
            w[s*16 +: 16] = 16'($urandom_range(0, 65535 / (taps + 1)));
         else if (style == 2)
            case ($urandom_range(0, 3))
               0: w[s*16 +: 16] = 16'h0000;
               1: w[s*16 +: 16] = 16'h8000;
               2: w[s*16 +: 16] = 16'hFFFF;
               default: ;
            endcase
      end
      return w;
   endfunction

   task automatic run_blur_phase(int phase, bit pause_midway);
      int taps;
      int offs;
      int style;
      int left;
      int len;
      bit paused;
      case (phase)
         0: begin taps = 15; offs = 0;  end
         1: begin taps = 1;  offs = 14; end
         2: begin taps = 15; offs = 15; end
         default: begin
            taps = $urandom_range(0, 15);
            offs = $urandom_range(0, 15);
         end
      endcase
      style = $urandom_range(0, 2);
      settle(CFG_QUIET);
      load_kernel(taps, offs, pick_coeff_word(style, taps), pick_coeff_word(style, taps),
                  pick_coeff_word(style, taps), pick_coeff_word(style, taps));
      @(posedge clock);
      left   = PHASE_ITEMS;
      paused = 1'b0;
      while (left > 0) begin
         // once, drain everything in the middle of the phase before going on
         if (pause_midway && !paused && left <= PHASE_ITEMS / 2) begin
            settle(0);
            @(posedge clock);
            paused = 1'b1;
         end
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 12);
         if (len > left) len = left;
         queue_line(len, 1'b1);
         left -= len;
      end
   endtask

   // ---------------------------------------------------------------- test sequence

   initial begin
      kernel_taps     = 4'd1;
      kernel_offset   = 4'd0;
      kernel_coeff[0] = lfb_pkg::CFG_BITS'(32768);
      kernel_coeff[1] = '0;
      kernel_coeff[2] = '0;
      kernel_coeff[3] = '0;
      clear_line();

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset kernel passes samples through unchanged
      @(posedge clock);
      push_sample(8'h00, 1'b0);
      push_sample(8'hFF, 1'b0);
      push_sample(8'h55, 1'b0);
      push_sample(8'hAA, 1'b1);
      settle(CFG_QUIET);

      // writes to unmapped indexes leave the kernel alone
      write_reg(REG_SPARE_A, {$urandom, $urandom});
      write_reg(REG_SPARE_B, {$urandom, $urandom});
      @(posedge clock);
      push_sample(8'h3C, 1'b1);
      settle(CFG_QUIET);

      // taps 0..14 at full scale, unused slot 15 too: saturate; lines shorter than the lag
      load_kernel(15, 7, '1, '1, '1, '1);
      @(posedge clock);
      push_sample(8'hFF, 1'b0);
      push_sample(8'hFF, 1'b0);
      push_sample(8'hFF, 1'b1);
      push_sample(8'h80, 1'b1);
      settle(CFG_QUIET);

      // zero taps: one zero result per sample
      load_kernel(0, 0, '1, '1, '1, '1);
      @(posedge clock);
      push_sample(8'hC8, 1'b0);
      push_sample(8'h11, 1'b1);
      settle(CFG_QUIET);

      // offset reaching past the window edge
      load_kernel(3, 15, {$urandom, $urandom}, {$urandom, $urandom}, '0, '0);
      @(posedge clock);
      push_sample(8'd10, 1'b0);
      push_sample(8'd20, 1'b0);
      push_sample(8'd30, 1'b1);
      settle(CFG_QUIET);

      // retune the center in the middle of a line
      load_kernel(5, 0, 64'h2000_4000_2000_1000, 64'h0000_0000_0000_1000, '0, '0);
      @(posedge clock);
      queue_line(4, 1'b0);
      settle(CFG_QUIET);
      write_reg(lfb_pkg::REG_CENTER_OFFSET, lfb_pkg::CFG_BITS'(2));
      @(posedge clock);
      queue_line(3, 1'b1);

      for (int p = 0; p < RANDOM_PHASES; p++)
         run_blur_phase(p, p == 4);

      settle(CFG_QUIET);
      if (blurred_q.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, blurred_q.size());
         error_count++;
      end
      $display("Checked %0d filtered samples from %0d requests over %0d lines, %0d kernels.",
               results_seen, req_accepted, lines_sent, kernels_used);
      $display("Run covered zero taps, saturation, out-of-window offsets, a mid-line retune.");
      if (error_count == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule

[line_fir_blur_unit.f]
rtl/lfb_pkg.sv
rtl/lfb_cell.sv
rtl/lfb_mac.sv
rtl/line_fir_blur_unit.sv
rtl/lfb_checker.sv
tb/sv/tb_top.sv
